// File: rtl/pwb_pkg.sv
// posted write buffer package: sizes, mode and state codes, store command type
// no dependencies; imported by every module of the buffer
package pwb_pkg;

  localparam int unsigned EntriesC = 4;
  localparam int unsigned IdxW     = (EntriesC > 1) ? $clog2(EntriesC) : 1;
  localparam int unsigned WordW    = 32;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [EntriesC-1:0] pend_t;
  typedef logic [WordW-1:0]    word_t;

  localparam idx_t LastIdx = idx_t'(EntriesC - 1);

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeRead  = 2'd1,
    ModeTick  = 2'd2,
    ModeFlush = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StWrite,
    StScan,
    StReq
  } state_e;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_idx;
    word_t wr_addr;
    word_t wr_data;
    logic  clr_en;
    idx_t  clr_idx;
  } store_cmd_t;

endpackage

// File: rtl/pwb_if.sv
// request and bus channel interfaces of the posted write buffer
// depends on pwb_pkg
interface pwb_req_if;
  import pwb_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] mode;
  word_t address;
  word_t value;

  modport source (output valid, mode, address, value, input ready);
  modport sink   (input valid, mode, address, value, output ready);
endinterface

interface pwb_bus_if;
  import pwb_pkg::*;
  logic  valid;
  logic  ready;
  logic  bus_is_write;
  word_t bus_address;
  word_t bus_data;
  logic  stalled;
  logic  last;

  modport source (output valid, bus_is_write, bus_address, bus_data, stalled, last,
                  input ready);
  modport sink   (input valid, bus_is_write, bus_address, bus_data, stalled, last,
                  output ready);
endinterface

// File: rtl/posted_write_buffer_unit.sv
// posted write buffer top level: one request in, bus requests out
// write: stores into the next slot, evicting its old contents as a bus write when still pending;
// tick, flush and read scan one slot per cycle over the EntriesC slots, holding on a pending slot
// while the bus output is busy; read then issues the read request; a new request is taken only in idle
// reset: pending bits, slot pointer and output valid clear; entry contents undefined
// depends on pwb_pkg, pwb_if, pwb_store, pwb_seq
module posted_write_buffer_unit import pwb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  pwb_req_if.sink    req_i,
  pwb_bus_if.source  bus_o
);

  store_cmd_t cmd;
  idx_t       rd_idx;
  word_t      rd_addr;
  word_t      rd_data;
  pend_t      pending;

  pwb_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .rd_addr_o (rd_addr),
    .rd_data_o (rd_data),
    .pending_o (pending)
  );

  pwb_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_mode_i     (req_i.mode),
    .req_address_i  (req_i.address),
    .req_value_i    (req_i.value),
    .out_valid_o    (bus_o.valid),
    .out_ready_i    (bus_o.ready),
    .out_is_write_o (bus_o.bus_is_write),
    .out_address_o  (bus_o.bus_address),
    .out_data_o     (bus_o.bus_data),
    .out_stalled_o  (bus_o.stalled),
    .out_last_o     (bus_o.last),
    .cmd_o          (cmd),
    .rd_idx_o       (rd_idx),
    .rd_addr_i      (rd_addr),
    .rd_data_i      (rd_data),
    .pending_i      (pending)
  );

endmodule

// File: rtl/pwb_store.sv
// entry store: address and data per slot plus pending bits
// depends on pwb_pkg
module pwb_store import pwb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_cmd_t cmd_i,
  input  idx_t       rd_idx_i,
  output word_t      rd_addr_o,
  output word_t      rd_data_o,
  output pend_t      pending_o
);

  word_t addr_q [EntriesC];
  word_t data_q [EntriesC];
  pend_t pending_q, pending_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      addr_q[cmd_i.wr_idx] <= cmd_i.wr_addr;
      data_q[cmd_i.wr_idx] <= cmd_i.wr_data;
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (cmd_i.clr_en) begin
      pending_d[cmd_i.clr_idx] = 1'b0;
    end
    if (cmd_i.wr_en) begin
      pending_d[cmd_i.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  assign rd_addr_o = addr_q[rd_idx_i];
  assign rd_data_o = data_q[rd_idx_i];
  assign pending_o = pending_q;

endmodule

// File: rtl/pwb_seq.sv
// sequencer: request decode, slot scan over the store, bus output register
// depends on pwb_pkg; drives pwb_store through a store_cmd_t
module pwb_seq import pwb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [1:0] req_mode_i,
  input  word_t      req_address_i,
  input  word_t      req_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_is_write_o,
  output word_t      out_address_o,
  output word_t      out_data_o,
  output logic       out_stalled_o,
  output logic       out_last_o,
  output store_cmd_t cmd_o,
  output idx_t       rd_idx_o,
  input  word_t      rd_addr_i,
  input  word_t      rd_data_i,
  input  pend_t      pending_i
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  word_t  addr_q, addr_d;
  word_t  val_q, val_d;
  logic   any_q, any_d;
  idx_t   idx_q, idx_d;
  idx_t   slot_q, slot_d;

  logic   out_valid_q;
  logic   out_is_write_q, out_is_write_d;
  word_t  out_addr_q, out_addr_d;
  word_t  out_data_q, out_data_d;
  logic   out_stall_q, out_stall_d;
  logic   out_last_q, out_last_d;
  logic   load;

  logic   out_free;
  logic   cur_pend;
  pend_t  rest;

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_idx_o = (state_q == StWrite) ? slot_q : idx_q;
  assign cur_pend = pending_i[rd_idx_o];
  assign rest     = pending_i & ~(pend_t'(1) << idx_q);

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    addr_d         = addr_q;
    val_d          = val_q;
    any_d          = any_q;
    idx_d          = idx_q;
    slot_d         = slot_q;
    req_ready_o    = 1'b0;
    load           = 1'b0;
    out_is_write_d = 1'b1;
    out_addr_d     = rd_addr_i;
    out_data_d     = rd_data_i;
    out_stall_d    = 1'b0;
    out_last_d     = 1'b0;
    cmd_o          = '0;
    cmd_o.wr_idx   = slot_q;
    cmd_o.wr_addr  = addr_q;
    cmd_o.wr_data  = val_q;
    cmd_o.clr_idx  = idx_q;

    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          mode_d  = mode_e'(req_mode_i);
          addr_d  = req_address_i;
          val_d   = req_value_i;
          any_d   = |pending_i;
          idx_d   = '0;
          state_d = (mode_e'(req_mode_i) == ModeWrite) ? StWrite : StScan;
        end
      end
      StWrite: begin
        if (!cur_pend || out_free) begin
          // evict old slot contents when still pending
          load        = cur_pend;
          out_stall_d = 1'b1;
          out_last_d  = 1'b1;
          cmd_o.wr_en = 1'b1;
          slot_d      = (slot_q == LastIdx) ? '0 : slot_q + idx_t'(1);
          state_d     = StIdle;
        end
      end
      StScan: begin
        if (pending_i == '0) begin
          state_d = (mode_q == ModeRead) ? StReq : StIdle;
        end else if (cur_pend) begin
          if (out_free) begin
            load         = 1'b1;
            out_stall_d  = (mode_q == ModeRead) ? any_q : 1'b0;
            out_last_d   = (mode_q == ModeTick) || (mode_q == ModeFlush && rest == '0);
            cmd_o.clr_en = 1'b1;
            if (mode_q == ModeTick) begin
              state_d = StIdle;
            end else if (idx_q != LastIdx) begin
              idx_d = idx_q + idx_t'(1);
            end
          end
        end else if (idx_q != LastIdx) begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      StReq: begin
        if (out_free) begin
          load           = 1'b1;
          out_is_write_d = 1'b0;
          out_addr_d     = addr_q;
          out_data_d     = '0;
          out_stall_d    = any_q;
          out_last_d     = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    addr_q <= addr_d;
    val_q  <= val_d;
    any_q  <= any_d;
    idx_q  <= idx_d;
    if (load) begin
      out_is_write_q <= out_is_write_d;
      out_addr_q     <= out_addr_d;
      out_data_q     <= out_data_d;
      out_stall_q    <= out_stall_d;
      out_last_q     <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_is_write_o = out_is_write_q;
  assign out_address_o  = out_addr_q;
  assign out_data_o     = out_data_q;
  assign out_stalled_o  = out_stall_q;
  assign out_last_o     = out_last_q;

endmodule
